>>> hdl/skt_pkg.sv
package skt_pkg;

  // Table dimensions
  localparam int CAPACITY   = 64;
  localparam int INFO_BYTES = 8;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths of the stream items
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int INFO_W   = 64;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 88;

  // Payload bytes beyond INFO_BYTES are dropped on insert.
  localparam logic [INFO_W-1:0] INFO_MASK = {INFO_W{1'b1}} >> (INFO_W - 8 * INFO_BYTES);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_DELETED  = 3'd4,
    ST_MISSING  = 3'd5
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [INFO_W-1:0] info;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_HIT,
    S_SHUP,
    S_SHDN,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

>>> hdl/skt_ram.sv
module skt_ram
  import skt_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [CAPACITY];

  // One write port, one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/sorted_key_table_top.sv
// Sorted key table: one transaction in process at a time.
// Lookup: a binary search of at most ceil(log2(count+1)) steps, each step reading one entry
// and comparing its key; the result then waits until the output register is free.
// Insert moves each later entry up one place and then places the new entry; delete moves
// each later entry down one place. Moves are paced by the single write port.
// Reset clears the entry count and the control state; memory is not cleared.
module sorted_key_table_top
  import skt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // Fields from bit 0: op[1:0], key[33:2], info_word[97:34], data_len[101:98]
  input  logic [IN_W-1:0] s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // Fields from bit 0: status[2:0], position[8:3], info_out[72:9],
  // data_len_out[76:73], entry_count[83:77]
  output logic [OUT_W-1:0] m_tdata
);

  state_t state, state_next;

  // Latched request
  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [INFO_W-1:0] info_q;
  logic [LEN_W-1:0]  len_q;

  // Search and move bookkeeping
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] mid, mid_next;
  logic [IDX_W-1:0] src, src_next;
  logic [CNT_W:0]   mid_sum;
  logic             hit;

  // Result being built
  status_t           res_status, res_status_next;
  logic [POS_W-1:0]  res_pos, res_pos_next;
  logic [INFO_W-1:0] res_info, res_info_next;
  logic [LEN_W-1:0]  res_len, res_len_next;
  logic              out_load;

  // Output register
  status_t            m_status;
  logic [POS_W-1:0]   m_pos;
  logic [INFO_W-1:0]  m_info;
  logic [LEN_W-1:0]   m_len;
  logic [COUNT_W-1:0] m_count;

  // Memory port signals
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  entry_t           new_entry;

  skt_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {4'b0000, m_count, m_len, m_info, m_pos, m_status};

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign hit     = (lo < count) && (rd_data.key == key_q);

  assign new_entry.key  = key_q;
  assign new_entry.info = info_q;
  assign new_entry.len  = len_q;

  // Latch the request on acceptance, masking and saturating the payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= op_t'(s_tdata[1:0]);
      key_q  <= s_tdata[33:2];
      info_q <= s_tdata[97:34] & INFO_MASK;
      len_q  <= (s_tdata[101:98] > LEN_W'(INFO_BYTES)) ? LEN_W'(INFO_BYTES)
                                                         : s_tdata[101:98];
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    src        <= src_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_info   <= res_info_next;
    res_len    <= res_len_next;
  end

  // Output register: a finished result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_status <= res_status;
      m_pos    <= res_pos;
      m_info   <= res_info;
      m_len    <= res_len;
      m_count  <= COUNT_W'(count);
    end
  end

  // Sequencer: binary search, then lookup, update, insert with upward move, or delete
  // with downward move. A move reads one entry and writes the previous one
  // each cycle.
  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    src_next        = src;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_info_next   = res_info;
    res_len_next    = res_len;
    out_load        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = IDX_W'(lo);
    wr_data         = new_entry;
    rd_addr         = IDX_W'(lo);

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          lo_next    = '0;
          hi_next    = count;
          state_next = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_sum[CNT_W:1];
          rd_addr    = IDX_W'(mid_sum[CNT_W:1]);
          state_next = S_CMP;
        end else begin
          rd_addr    = IDX_W'(lo);
          state_next = S_HIT;
        end
      end

      S_CMP: begin
        if ($signed(rd_data.key) < $signed(key_q)) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end

      S_HIT: begin
        res_pos_next  = '0;
        res_info_next = '0;
        res_len_next  = '0;
        state_next    = S_DONE;
        unique case (op_q)
          OP_INSERT: begin
            if (count >= CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else if (hit) begin
              wr_en           = 1'b1;
              wr_addr         = IDX_W'(lo);
              wr_data.info    = info_q;
              wr_data.len     = len_q;
              wr_data.key     = rd_data.key;
              res_status_next = ST_UPDATED;
              res_pos_next    = POS_W'(lo);
            end else if (count > lo) begin
              src_next   = IDX_W'(count - CNT_W'(1));
              rd_addr    = IDX_W'(count - CNT_W'(1));
              state_next = S_SHUP;
            end else begin
              state_next = S_PLACE;
            end
          end
          OP_DELETE: begin
            if (hit) begin
              res_status_next = ST_DELETED;
              res_pos_next    = POS_W'(lo);
              if ((lo + CNT_W'(1)) < count) begin
                src_next   = IDX_W'(lo + CNT_W'(1));
                rd_addr    = IDX_W'(lo + CNT_W'(1));
                state_next = S_SHDN;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end else begin
              res_status_next = ST_MISSING;
            end
          end
          default: begin
            if (hit) begin
              res_status_next = ST_FOUND;
              res_pos_next    = POS_W'(lo);
              res_info_next   = rd_data.info;
              res_len_next    = rd_data.len;
            end else begin
              res_status_next = ST_MISSING;
            end
          end
        endcase
      end

      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = src + IDX_W'(1);
        wr_data = rd_data;
        rd_addr = src - IDX_W'(1);
        if (CNT_W'(src) == lo) begin
          state_next = S_PLACE;
        end else begin
          src_next = src - IDX_W'(1);
        end
      end

      S_PLACE: begin
        wr_en           = 1'b1;
        wr_addr         = IDX_W'(lo);
        wr_data         = new_entry;
        count_next      = count + CNT_W'(1);
        res_status_next = ST_INSERTED;
        res_pos_next    = POS_W'(lo);
        state_next      = S_DONE;
      end

      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = src - IDX_W'(1);
        wr_data = rd_data;
        rd_addr = src + IDX_W'(1);
        if (CNT_W'(src) == (count - CNT_W'(1))) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          src_next = src + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The entry count never exceeds the table size.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                     count == $past(count) - CNT_W'(1)))
    else $error("entry count jumped");

  // The memory is only written while an operation is in progress.
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !wr_en)
    else $error("memory write while idle");

  // A refused insert is reported only with a full table.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_status == ST_FULL) |-> (m_count == COUNT_W'(CAPACITY)))
    else $error("full status with free entries");

  // An accepted transaction always starts with the search.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_SEARCH))
    else $error("transaction not started");

endmodule
